FILE: rtl/core/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// shared types and constants of the 2-d median filter
// ----------------------------------------------------------------------------
package mf2d_pkg;

    localparam int MAX_KERNEL_DEF = 7;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int ROW_W          = 13;   // holds 0 .. MAX_HEIGHT
    localparam int PIX_W          = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [2:0]  KERNEL_RST = 3'd3;
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             drain;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             frame_end;
    } t_pix_out;

endpackage

FILE: rtl/core/median_filter_2d.sv
// ----------------------------------------------------------------------------
// median_filter_2d
// streaming median over a clipped square window, rows kept in a line store
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_stall     i_in_data  (pixel, drain)
//  out       source     o_out_valid / i_out_stall   o_out_data (filtered, frame_end)
//  cfg       sink       i_cfg_we                    i_cfg_index, i_cfg_data
//
//  a transaction that emits nothing passes through accept and readiness check
//  an emitting transaction also scans the clipped window (up to 49 values) with
//  one line store read per window value from its one port, then picks and emits
//  window values are ranked by a parallel insertion array as they arrive
//  synchronous active-low reset clears control state and the configuration registers
//  the result waits in an output register, so a stalled sink does not block
//  the next input transaction until a second result is ready
// ----------------------------------------------------------------------------
module median_filter_2d #(
    parameter int MAX_KERNEL = mf2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mf2d_pkg::t_pix_in                     i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mf2d_pkg::t_pix_out                    o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mf2d_pkg::*;

    localparam int MAX_HALF = (MAX_KERNEL - 1) / 2;
    localparam int RING     = MAX_KERNEL + 1;
    localparam int WIN      = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
    localparam int RNG_W    = $clog2(RING);
    localparam int COL_W    = $clog2(MAX_WIDTH + 1);
    localparam int ADR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W    = $clog2(WIN + 1);
    localparam int IDX_W    = (WIN > 1) ? $clog2(WIN) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_READ, S_LAST, S_PICK_HI, S_PICK_LO, S_EMIT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [2:0]  r_kernel;
    logic [10:0] r_width;
    logic [12:0] r_height;

    // frame position counters
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [RNG_W-1:0] r_in_ring, r_out_ring;
    logic             r_in_done;

    // window scan
    logic [ROW_W-1:0] r_cr, r_r1;
    logic [COL_W-1:0] r_cc, r_c0, r_c1;
    logic [RNG_W-1:0] r_cring;
    logic             r_rd_pend;
    logic [PIX_W-1:0] r_rd_data;

    // ranking array
    logic [PIX_W-1:0] r_sort [WIN];
    logic [PIX_W-1:0] n_sort [WIN];
    logic [WIN-1:0]   w_le;
    logic [CNT_W-1:0] r_cnt;
    logic [PIX_W-1:0] r_hi, r_lo;

    // output register
    logic             r_ov;
    t_pix_out         r_od;

    // line store
    logic [PIX_W-1:0] mem [RING][MAX_WIDTH];

    // effective configuration
    logic [2:0]       w_half;
    logic [COL_W-1:0] w_w;
    logic [ROW_W-1:0] w_h;
    logic [10:0]      w_wr;
    logic [12:0]      w_hr;

    always_comb begin
        w_half = ({1'b0, r_kernel[2:1]} > 3'(MAX_HALF)) ? 3'(MAX_HALF) : {1'b0, r_kernel[2:1]};
        w_wr   = (r_width == 11'd0) ? 11'd1 : r_width;
        w_w    = (32'(w_wr) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : COL_W'(w_wr);
        w_hr   = (r_height == 13'd0) ? 13'd1 : r_height;
        w_h    = (32'(w_hr) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT) : ROW_W'(w_hr);
    end

    // window bounds around the output position
    logic [ROW_W-1:0] w_r0, w_nr, w_d;
    logic [COL_W-1:0] w_c0, w_nc;
    logic [RNG_W:0]   w_ring0;
    logic             w_ready, w_last, w_oob;

    always_comb begin
        w_r0 = (r_out_row >= ROW_W'(w_half)) ? r_out_row - ROW_W'(w_half) : '0;
        w_nr = (r_out_row + ROW_W'(w_half) < w_h) ? r_out_row + ROW_W'(w_half) : w_h - 1'b1;
        w_c0 = (r_out_col >= COL_W'(w_half)) ? r_out_col - COL_W'(w_half) : '0;
        w_nc = (r_out_col + COL_W'(w_half) < w_w) ? r_out_col + COL_W'(w_half) : w_w - 1'b1;
        w_d  = r_out_row - w_r0;
        // ring row of the top window row
        w_ring0 = ({1'b0, r_out_ring} >= (RNG_W+1)'(w_d))
                ? {1'b0, r_out_ring} - (RNG_W+1)'(w_d)
                : {1'b0, r_out_ring} + (RNG_W+1)'(RING) - (RNG_W+1)'(w_d);
        w_ready = r_in_done || (r_in_row > w_nr) || ((r_in_row == w_nr) && (r_in_col > w_nc));
        w_last  = (r_out_row == w_h - 1'b1) && (r_out_col == w_w - 1'b1);
        w_oob   = (r_out_row >= w_h) || (r_out_col >= w_w);
    end

    // insertion of the arriving value into the ascending array
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            w_le[i] = (CNT_W'(i) < r_cnt) && (r_sort[i] <= r_rd_data);
        end
        n_sort[0] = w_le[0] ? r_sort[0] : r_rd_data;
        for (int i = 1; i < WIN; i++) begin
            if (w_le[i]) begin
                n_sort[i] = r_sort[i];
            end else if (w_le[i-1]) begin
                n_sort[i] = r_rd_data;
            end else begin
                n_sort[i] = r_sort[i-1];
            end
        end
    end

    logic [CNT_W-1:0] w_mid;
    logic [8:0]       w_avg;
    logic             w_accept, w_emit;

    assign w_mid    = r_cnt >> 1;
    assign w_avg    = ({1'b0, r_hi} + {1'b0, r_lo}) >> 1;
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_emit   = (r_state == S_EMIT) && (!r_ov || !i_out_stall);

    // line store: written on an accepted non-drain pixel of an unfinished frame, read during the window scan
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_in_data.drain && !r_in_done) begin
            mem[r_in_ring][r_in_col[ADR_W-1:0]] <= i_in_data.pixel;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[r_cring][r_cc[ADR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_kernel   <= KERNEL_RST;
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_in_done  <= 1'b0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_rd_pend  <= 1'b0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
        end else begin
            // output register: loaded on emit, freed when its transaction leaves
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_in_data.drain && !r_in_done) begin
                            if (r_in_col + 1'b1 >= w_w) begin
                                r_in_col  <= '0;
                                r_in_row  <= r_in_row + 1'b1;
                                r_in_ring <= (32'(r_in_ring) == RING - 1) ? '0
                                                                           : r_in_ring + 1'b1;
                                if (r_in_row + 1'b1 >= w_h) begin
                                    r_in_done <= 1'b1;
                                end
                            end else begin
                                r_in_col <= r_in_col + 1'b1;
                            end
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_oob) begin
                        r_in_row   <= '0;
                        r_in_col   <= '0;
                        r_in_ring  <= '0;
                        r_in_done  <= 1'b0;
                        r_out_row  <= '0;
                        r_out_col  <= '0;
                        r_out_ring <= '0;
                        r_state    <= S_IDLE;
                    end else if (w_ready) begin
                        r_cr      <= w_r0;
                        r_r1      <= w_nr;
                        r_cc      <= w_c0;
                        r_c0      <= w_c0;
                        r_c1      <= w_nc;
                        r_cring   <= RNG_W'(w_ring0);
                        r_cnt     <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_READ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_rd_pend <= 1'b1;
                    if (r_rd_pend) begin
                        r_sort <= n_sort;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                    if (r_cc == r_c1) begin
                        if (r_cr == r_r1) begin
                            r_state <= S_LAST;
                        end else begin
                            r_cc    <= r_c0;
                            r_cr    <= r_cr + 1'b1;
                            r_cring <= (32'(r_cring) == RING - 1) ? '0 : r_cring + 1'b1;
                        end
                    end else begin
                        r_cc <= r_cc + 1'b1;
                    end
                end
                S_LAST: begin
                    r_sort  <= n_sort;
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_PICK_HI;
                end
                S_PICK_HI: begin
                    r_hi    <= r_sort[w_mid[IDX_W-1:0]];
                    r_state <= r_cnt[0] ? S_EMIT : S_PICK_LO;
                end
                S_PICK_LO: begin
                    r_lo    <= r_sort[IDX_W'(w_mid - 1'b1)];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_od.filtered     <= r_cnt[0] ? r_hi : w_avg[PIX_W-1:0];
                        r_od.frame_end    <= w_last;
                        if (w_last) begin
                            r_in_row   <= '0;
                            r_in_col   <= '0;
                            r_in_ring  <= '0;
                            r_in_done  <= 1'b0;
                            r_out_row  <= '0;
                            r_out_col  <= '0;
                            r_out_ring <= '0;
                        end else if (r_out_col + 1'b1 >= w_w) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + 1'b1;
                            r_out_ring <= (32'(r_out_ring) == RING - 1) ? '0
                                                                         : r_out_ring + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // a register write restarts the frame
            if (i_cfg_we && (i_cfg_index == CFG_KERNEL || i_cfg_index == CFG_WIDTH
                             || i_cfg_index == CFG_HEIGHT)) begin
                case (i_cfg_index)
                    CFG_KERNEL: r_kernel <= i_cfg_data[2:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                    default:    r_kernel <= r_kernel;
                endcase
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_ring  <= '0;
                r_in_done  <= 1'b0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_ring <= '0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    // ranking array never overfills
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CNT_W'(WIN))
        else $error("window count overflow");

    // an accepted transaction is always checked for readiness next
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("accept not followed by check");

    // a median is only picked from a non-empty window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK_HI) |-> (r_cnt != '0))
        else $error("empty window ranked");

    // output position stays inside the frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_out_row < w_h && r_out_col < w_w))
        else $error("output position outside frame");

endmodule
